// ===== src/bfdh_pkg.sv =====
package bfdh_pkg;

    localparam int FILTER_BITS  = 1024;
    localparam int MAX_PROBES   = 8;
    localparam int FILTER_WORDS = (FILTER_BITS + 63) / 64;
    localparam int WORD_AW      = $clog2(FILTER_WORDS);
    localparam int POS_W        = $clog2(FILTER_BITS);
    localparam int NBITS_W      = 11;
    localparam int NHASH_W      = 4;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int MOD_STEPS    = 8;

    localparam logic [63:0] DJB_START = 64'd5381;
    localparam logic [63:0] FNV_START = 64'd14695981039346656037;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 2'd1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage

// ===== src/bfdh_ram.sv =====
module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bfdh_mod.sv =====
module bfdh_mod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [63:0]                  dividend,
    input  logic [bfdh_pkg::NBITS_W-1:0] divisor,
    output logic                         done,
    output logic [bfdh_pkg::POS_W-1:0]   remainder
);

    import bfdh_pkg::*;

    localparam int CNT_W = $clog2(64 / MOD_STEPS);

    logic [63:0]      dvd_reg, dvd_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        logic [POS_W:0] t;
        logic [POS_W-1:0] r;
        r = rem_reg;
        for (int j = 0; j < MOD_STEPS; j++)
        begin
            t = {r, dvd_reg[63-j]};
            if (t >= divisor)
            begin
                t = t - divisor;
            end
            r = t[POS_W-1:0];
        end
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << MOD_STEPS;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(64 / MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/bloom_filter_double_hash.sv =====
// Bloom filter over byte-serial keys with djb2/FNV-1a double hashing. Each key byte is
// one item and is folded into both hashes combinationally as it is accepted; a key's
// last byte starts the probing, during which input is stalled. Each probe starts the
// modulo unit, which reduces the 64-bit probe value by num_bits eight bits per cycle,
// then registers the remainder and reads the 16 x 64 filter memory, and then does the
// read-modify-write. After a key's last byte the input is stalled through its probes,
// for a query also until the result is registered, and longer while a query's result
// waits on a stalled output. A query yields one item on maybe_present; an insert yields
// none. The filter is cleared at reset by per-word valid flags.
module bloom_filter_double_hash (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfdh_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [7:0]                     key_byte,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           maybe_present
);

    import bfdh_pkg::*;

    typedef enum logic [2:0] {IDLE, ISSUE, WAIT, RMW, FINISH} state_t;

    state_t                   state_reg, state_next;
    logic [NBITS_W-1:0]       num_bits_reg;
    logic [NHASH_W-1:0]       num_hashes_reg;
    logic [63:0]              djb_reg, djb_next, fnv_reg, fnv_next;
    logic [63:0]              probe_reg, probe_next, step_reg, step_next;
    logic                     cmd_reg, cmd_next;
    logic                     all_reg, all_next;
    logic [NHASH_W-1:0]       k_reg, k_next, idx_reg, idx_next;
    logic [NBITS_W-1:0]       n_reg, n_next;
    logic [5:0]               bit_reg, bit_next;
    logic [WORD_AW-1:0]       addr_reg, addr_next;
    logic [FILTER_WORDS-1:0]  wvalid_reg, wvalid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_data_reg, out_data_next;
    logic                     mod_start;
    logic                     mod_done;
    logic [POS_W-1:0]         rem;
    logic [63:0]              rdata, word, wdata;
    logic                     ram_we, ram_re;
    logic [63:0]              djb_new, fnv_x, fnv_new;
    logic [NBITS_W-1:0]       n_act;
    logic [NHASH_W-1:0]       k_act;

    assign djb_new = (djb_reg << 5) + djb_reg + {56'd0, key_byte};
    assign fnv_x   = fnv_reg ^ {56'd0, key_byte};
    assign fnv_new = (fnv_x << 40) + (fnv_x << 8) + (fnv_x << 7) + (fnv_x << 5)
                     + (fnv_x << 4) + (fnv_x << 1) + fnv_x;

    always_comb
    begin
        n_act = num_bits_reg;
        if (num_bits_reg == '0)
        begin
            n_act = NBITS_W'(1);
        end
        else if (num_bits_reg > NBITS_W'(FILTER_BITS))
        begin
            n_act = NBITS_W'(FILTER_BITS);
        end
        k_act = num_hashes_reg;
        if (num_hashes_reg > NHASH_W'(MAX_PROBES))
        begin
            k_act = NHASH_W'(MAX_PROBES);
        end
    end

    assign word  = wvalid_reg[addr_reg] ? rdata : 64'd0;
    assign wdata = word | (64'd1 << bit_reg);

    bfdh_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (probe_reg),
        .divisor   (n_reg),
        .done      (mod_done),
        .remainder (rem)
    );

    bfdh_ram #(
        .WIDTH (64),
        .DEPTH (FILTER_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (rem[POS_W-1:6]),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        djb_next       = djb_reg;
        fnv_next       = fnv_reg;
        probe_next     = probe_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        all_next       = all_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        bit_next       = bit_reg;
        addr_next      = addr_reg;
        wvalid_next    = wvalid_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mod_start      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    djb_next = djb_new;
                    fnv_next = fnv_new;
                    if (last)
                    begin
                        djb_next   = DJB_START;
                        fnv_next   = FNV_START;
                        probe_next = djb_new;
                        step_next  = fnv_new;
                        cmd_next   = cmd;
                        all_next   = 1'b1;
                        k_next     = k_act;
                        n_next     = n_act;
                        idx_next   = '0;
                        if (k_act != '0)
                        begin
                            state_next = ISSUE;
                        end
                        else if (cmd == CMD_QUERY)
                        begin
                            state_next = FINISH;
                        end
                    end
                end
            end
            ISSUE:
            begin
                mod_start  = 1'b1;
                state_next = WAIT;
            end
            WAIT:
            begin
                if (mod_done)
                begin
                    ram_re     = 1'b1;
                    addr_next  = rem[POS_W-1:6];
                    bit_next   = rem[5:0];
                    state_next = RMW;
                end
            end
            RMW:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    ram_we                = 1'b1;
                    wvalid_next[addr_reg] = 1'b1;
                end
                else if (!word[bit_reg])
                begin
                    all_next = 1'b0;
                end
                idx_next   = idx_reg + 1'b1;
                probe_next = probe_reg + step_reg;
                if (idx_reg + 1'b1 == k_reg)
                begin
                    state_next = (cmd_reg == CMD_QUERY) ? FINISH : IDLE;
                end
                else
                begin
                    state_next = ISSUE;
                end
            end
            FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = all_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            num_bits_reg   <= NBITS_W'(FILTER_BITS);
            num_hashes_reg <= NHASH_W'(3);
            djb_reg        <= DJB_START;
            fnv_reg        <= FNV_START;
            wvalid_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            djb_reg       <= djb_next;
            fnv_reg       <= fnv_next;
            wvalid_reg    <= wvalid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_BITS:   num_bits_reg   <= cfg_data[NBITS_W-1:0];
                    REG_NUM_HASHES: num_hashes_reg <= cfg_data[NHASH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg    <= probe_next;
        step_reg     <= step_next;
        cmd_reg      <= cmd_next;
        all_reg      <= all_next;
        k_reg        <= k_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        bit_reg      <= bit_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall      = (state_reg != IDLE);
    assign out_valid     = out_valid_reg;
    assign maybe_present = out_data_reg;

endmodule

// ===== test/bloom_filter_double_hash_tb.sv =====
module bloom_filter_double_hash_tb;
    import bfdh_pkg::*;

    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam int          SETTLE_CYC = 150;

    class filter_scoreboard;
        bit [63:0]            djb;
        bit [63:0]            fnv;
        bit [FILTER_BITS-1:0] filt;
        bit [NBITS_W-1:0]     num_bits;
        bit [NHASH_W-1:0]     num_hashes;
        bit                   answers[$];
        int                   errors;

        function void clear();
            djb        = DJB_START;
            fnv        = FNV_START;
            filt       = '0;
            num_bits   = 11'd1024;
            num_hashes = 4'd3;
            errors     = 0;
            answers.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_NUM_BITS)
                num_bits = data[NBITS_W-1:0];
            else if (idx == REG_NUM_HASHES)
                num_hashes = data[NHASH_W-1:0];
        endfunction

        function void note_item(logic c, logic [7:0] b, logic l);
            bit [63:0] n;
            bit [63:0] k;
            bit [63:0] pos;
            bit        hit;
            djb = djb * 64'd33 + {56'd0, b};
            fnv = (fnv ^ {56'd0, b}) * FNV_PRIME;
            if (!l)
                return;
            n = (num_bits == 0) ? 64'd1 : (num_bits > FILTER_BITS) ? FILTER_BITS : num_bits;
            k = (num_hashes > MAX_PROBES) ? MAX_PROBES : num_hashes;
            hit = 1'b1;
            for (bit [63:0] i = 0; i < k; i++)
            begin
                pos = (djb + i * fnv) % n;
                if (c == CMD_INSERT)
                    filt[pos] = 1'b1;
                else if (!filt[pos])
                    hit = 1'b0;
            end
            djb = DJB_START;
            fnv = FNV_START;
            if (c == CMD_QUERY)
                answers = {answers, hit};
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic got);
            bit want;
            if (answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected maybe_present=%0b", got));
                return;
            end
            want = answers.pop_front();
            if (got !== want)
                report_mismatch($sformatf("maybe_present=%0b, expected %0b", got, want));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 cmd = 1'b0;
    logic [7:0]           key_byte = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 maybe_present;

    filter_scoreboard sb;
    bit               quiet = 1'b0;
    int               items_sent = 0;
    bit [47:0]        known_keys[$];
    int               known_lens[$];

    bloom_filter_double_hash DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .key_byte(key_byte), .last(last), .out_valid(out_valid), .out_stall(out_stall),
        .maybe_present(maybe_present)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (quiet || !rst_n)
                out_stall <= 1'b0;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 8) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(maybe_present);
        end
    end

    task send_item(logic c, logic [7:0] b, logic l);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key_byte <= b;
        last     <= l;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        sb.note_item(c, b, l);
        items_sent++;
    endtask

    task send_key(logic c, bit [47:0] k, int len);
        for (int j = 0; j < len; j++)
            send_item((j == len - 1) ? c : logic'($urandom_range(0, 1)), k[8*j +: 8],
                      j == len - 1);
        if (c == CMD_INSERT && known_keys.size() < 64)
        begin
            known_keys = {known_keys, k};
            known_lens = {known_lens, len};
        end
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.answers.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task random_keys(int count);
        int        stop_at;
        int        pick;
        bit [47:0] k;
        int        len;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if (known_keys.size() > 0 && $urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, known_keys.size() - 1);
                send_key(CMD_QUERY, known_keys[pick], known_lens[pick]);
            end
            else
            begin
                k   = {$urandom, $urandom};
                len = $urandom_range(1, 6);
                send_key(logic'($urandom_range(0, 1)), k, len);
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings[9][2];
        sb = new();
        sb.clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_key(CMD_QUERY, 48'h0, 1);
        send_key(CMD_INSERT, 48'h0, 1);
        send_key(CMD_QUERY, 48'h0, 1);
        send_key(CMD_INSERT, 48'hFF_FFFF, 3);
        send_key(CMD_QUERY, 48'hFF_FFFF, 3);
        send_key(CMD_QUERY, 48'hFF_FFFE, 3);
        send_key(CMD_INSERT, 48'h5A_A5_0F_F0_80_01, 6);
        send_key(CMD_QUERY, 48'h5A_A5_0F_F0_80_01, 6);
        send_key(CMD_QUERY, 48'hA5_5A_F0_0F_7F_FE, 6);
        drain();

        settings = '{'{11'd1, 11'd1}, '{11'd0, 11'd0}, '{11'd2047, 11'd15},
                     '{11'd1024, 11'd8}, '{11'd64, 11'h7F2}, '{11'd1, 11'd8},
                     '{11'd700, 11'd5}, '{11'd1025, 11'd9}, '{11'd333, 11'd3}};
        for (int p = 0; p < 9; p++)
        begin
            write_reg(REG_NUM_BITS, settings[p][0]);
            write_reg(REG_NUM_HASHES, settings[p][1]);
            write_reg(2'd2, CFG_W'($urandom));
            write_reg(2'd3, CFG_W'($urandom));
            if (p == 0)
            begin
                send_key(CMD_QUERY, 48'h7, 1);
                send_key(CMD_INSERT, 48'h7, 1);
                send_key(CMD_QUERY, 48'h8, 1);
            end
            if (p == 8)
                quiet = 1'b1;
            random_keys(155);
            drain();
        end

        if (sb.errors == 0 && sb.answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
